// ----- hdl/sis_pkg.sv -----
`default_nettype none
package sis_pkg;

  // field widths
  localparam int unsigned CoordW  = 20;
  localparam int unsigned EntryW  = 20;
  localparam int unsigned RowW    = 3 * EntryW;
  localparam int unsigned ErrW    = 24;
  localparam int unsigned CntW    = 17;
  localparam int unsigned SumW    = 40;
  localparam int unsigned CfgIdxW = 2;

  // datapath widths
  localparam int unsigned ExW   = 42;             // Ex, E^T x' in Q.31
  localparam int unsigned PW    = 64;             // epipolar product in Q.45
  localparam int unsigned DW    = 58;             // sum of squares in Q.34
  localparam int unsigned MulW  = 28;             // shared multiplier operand
  localparam int unsigned ProdW = 2 * MulW;
  localparam int unsigned SqW   = 29;             // integer square root
  localparam int unsigned MagW  = 36;             // |P| >> 28
  localparam int unsigned NumW  = MagW + 16;      // dividend m << 16
  localparam int unsigned IterW = 6;
  localparam int unsigned StepW = 5;

  // sequencer lengths
  localparam logic [StepW-1:0] StepLast  = StepW'(17);
  localparam logic [IterW-1:0] SqrtLast  = IterW'(SqW - 1);
  localparam logic [IterW-1:0] DivLast   = IterW'(NumW - 1);

  localparam logic [ErrW-1:0] ErrMax = '1;
  localparam logic [SumW-1:0] SumMax = '1;

  localparam int unsigned MaxMatchesDef = 65536;
  localparam int unsigned QueueDepth    = 2;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_E_ROW0     = 2'd0,
    CFG_E_ROW1     = 2'd1,
    CFG_E_ROW2     = 2'd2,
    CFG_THRESHOLD  = 2'd3
  } cfg_idx_e;

  // classified match handed from front to back
  typedef struct packed {
    logic [ErrW-1:0] err;
    logic            invalid;
    logic            run_start;
    logic            model_last;
  } sis_item_t;

endpackage
`default_nettype wire

// ----- hdl/sampson_inlier_scoring_top.sv -----
// Sampson inlier scoring: scores one essential matrix (written through the
// configuration port as three packed rows plus the threshold) against a stream
// of normalized matches, one result per match. A match runs on one shared 28x28
// multiplier for Ex, E^T x', the epipolar product and the squares, a load step,
// a bit-pair square root, a restoring divider and a hand-off step (root and
// divide are skipped when its denominator is zero); the front takes a new match
// only after the hand-off. Scored matches go through a two-entry queue to the
// accumulator, which keeps the running inlier count, residual sum and best
// record and holds the result in an output register, so the arithmetic front
// can start the next match while a result waits. Configuration must be written
// only while no match is in flight; the block itself does not enforce it.
`default_nettype none
module sampson_inlier_scoring_top #(
  parameter int unsigned MAX_MATCHES = sis_pkg::MaxMatchesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sis_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [sis_pkg::RowW-1:0]          cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [sis_pkg::CoordW-1:0] first_x_i,
  input  logic signed [sis_pkg::CoordW-1:0] first_y_i,
  input  logic signed [sis_pkg::CoordW-1:0] second_x_i,
  input  logic signed [sis_pkg::CoordW-1:0] second_y_i,
  input  logic                              run_start_i,
  input  logic                              model_last_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sis_pkg::ErrW-1:0]          sampson_err_o,
  output logic                              is_inlier_o,
  output logic                              is_invalid_o,
  output logic [sis_pkg::CntW-1:0]          model_inliers_o,
  output logic [sis_pkg::SumW-1:0]          model_residual_o,
  output logic                              new_best_o,
  output logic                              model_done_o
);
  import sis_pkg::*;

  logic [RowW-1:0] e_row0_q, e_row1_q, e_row2_q;
  logic [ErrW-1:0] threshold_q;
  logic            cfg_we;
  cfg_idx_e        cfg_idx;

  logic      push, full, pop, empty;
  sis_item_t push_item, pop_item;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_idx     = cfg_idx_e'(cfg_index_i);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_row0_q    <= '0;
      e_row1_q    <= '0;
      e_row2_q    <= '0;
      threshold_q <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_E_ROW0:    e_row0_q    <= cfg_data_i;
        CFG_E_ROW1:    e_row1_q    <= cfg_data_i;
        CFG_E_ROW2:    e_row2_q    <= cfg_data_i;
        CFG_THRESHOLD: threshold_q <= cfg_data_i[ErrW-1:0];
        default: ;
      endcase
    end
  end

  // arithmetic front
  sis_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .e_row0_i     (e_row0_q),
    .e_row1_i     (e_row1_q),
    .e_row2_i     (e_row2_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .first_x_i    (first_x_i),
    .first_y_i    (first_y_i),
    .second_x_i   (second_x_i),
    .second_y_i   (second_y_i),
    .run_start_i  (run_start_i),
    .model_last_i (model_last_i),
    .push_o       (push),
    .push_item_o  (push_item),
    .full_i       (full)
  );

  // queue between front and back
  sis_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_item_o  (pop_item)
  );

  // accumulator and result register
  sis_back #(
    .MAX_MATCHES (MAX_MATCHES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .threshold_i      (threshold_q),
    .empty_i          (empty),
    .item_i           (pop_item),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sampson_err_o    (sampson_err_o),
    .is_inlier_o      (is_inlier_o),
    .is_invalid_o     (is_invalid_o),
    .model_inliers_o  (model_inliers_o),
    .model_residual_o (model_residual_o),
    .new_best_o       (new_best_o),
    .model_done_o     (model_done_o)
  );

endmodule
`default_nettype wire

// ----- hdl/sis_front.sv -----
`default_nettype none
module sis_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [sis_pkg::RowW-1:0]        e_row0_i,
  input  logic [sis_pkg::RowW-1:0]        e_row1_i,
  input  logic [sis_pkg::RowW-1:0]        e_row2_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [sis_pkg::CoordW-1:0] first_x_i,
  input  logic signed [sis_pkg::CoordW-1:0] first_y_i,
  input  logic signed [sis_pkg::CoordW-1:0] second_x_i,
  input  logic signed [sis_pkg::CoordW-1:0] second_y_i,
  input  logic                            run_start_i,
  input  logic                            model_last_i,
  output logic                            push_o,
  output sis_pkg::sis_item_t              push_item_o,
  input  logic                            full_i
);
  import sis_pkg::*;

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_MUL  = 6'b000010,
    F_PREP = 6'b000100,
    F_SQRT = 6'b001000,
    F_DIV  = 6'b010000,
    F_PUSH = 6'b100000
  } front_state_e;

  front_state_e state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic phase_q, phase_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic signed [CoordW-1:0] x_q, y_q, xp_q, yp_q;
  logic start_q, last_q;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [ExW-1:0] ex0_q, ex0_d, ex1_q, ex1_d, ex2_q, ex2_d, et0_q, et0_d, et1_q, et1_d;
  logic signed [PW-1:0] p_q, p_d;
  logic [DW-1:0] d_q, d_d;
  logic [DW-1:0] sq_v_q, sq_v_d, sq_res_q, sq_res_d, sq_bit_q, sq_bit_d;
  logic [NumW-1:0] num_q, num_d;
  logic [SqW-1:0] rem_q, rem_d;
  logic [ErrW-1:0] err_q, err_d;
  logic inv_q, inv_d;
  logic accept;

  // matrix entries, sign extended to the multiplier width
  logic signed [MulW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [MulW-1:0] cx, cy, cxp, cyp;
  logic signed [MulW-1:0] mul_a, mul_b;

  function automatic logic signed [MulW-1:0] sx20(input logic [EntryW-1:0] v);
    sx20 = {{(MulW-EntryW){v[EntryW-1]}}, v};
  endfunction

  function automatic logic signed [ExW-1:0] sh14(input logic [EntryW-1:0] v);
    sh14 = {{(ExW-EntryW-14){v[EntryW-1]}}, v, 14'b0};
  endfunction

  assign e00 = sx20(e_row0_i[0*EntryW +: EntryW]);
  assign e01 = sx20(e_row0_i[1*EntryW +: EntryW]);
  assign e02 = sx20(e_row0_i[2*EntryW +: EntryW]);
  assign e10 = sx20(e_row1_i[0*EntryW +: EntryW]);
  assign e11 = sx20(e_row1_i[1*EntryW +: EntryW]);
  assign e12 = sx20(e_row1_i[2*EntryW +: EntryW]);
  assign e20 = sx20(e_row2_i[0*EntryW +: EntryW]);
  assign e21 = sx20(e_row2_i[1*EntryW +: EntryW]);
  assign e22 = sx20(e_row2_i[2*EntryW +: EntryW]);
  assign cx  = sx20(x_q);
  assign cy  = sx20(y_q);
  assign cxp = sx20(xp_q);
  assign cyp = sx20(yp_q);

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == F_IDLE);

  // operand select for the shared multiplier, one product per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      5'd0:  begin mul_a = e00; mul_b = cx;  end
      5'd1:  begin mul_a = e01; mul_b = cy;  end
      5'd2:  begin mul_a = e10; mul_b = cx;  end
      5'd3:  begin mul_a = e11; mul_b = cy;  end
      5'd4:  begin mul_a = e20; mul_b = cx;  end
      5'd5:  begin mul_a = e21; mul_b = cy;  end
      5'd6:  begin mul_a = e00; mul_b = cxp; end
      5'd7:  begin mul_a = e10; mul_b = cyp; end
      5'd8:  begin mul_a = e01; mul_b = cxp; end
      5'd9:  begin mul_a = e11; mul_b = cyp; end
      5'd10: begin mul_a = cxp; mul_b = {{(MulW-21){1'b0}}, ex0_q[20:0]}; end
      5'd11: begin mul_a = cxp; mul_b = {{(MulW-21){ex0_q[ExW-1]}}, ex0_q[ExW-1:21]}; end
      5'd12: begin mul_a = cyp; mul_b = {{(MulW-21){1'b0}}, ex1_q[20:0]}; end
      5'd13: begin mul_a = cyp; mul_b = {{(MulW-21){ex1_q[ExW-1]}}, ex1_q[ExW-1:21]}; end
      5'd14: begin mul_a = ex0_q[ExW-1:14]; mul_b = ex0_q[ExW-1:14]; end
      5'd15: begin mul_a = ex1_q[ExW-1:14]; mul_b = ex1_q[ExW-1:14]; end
      5'd16: begin mul_a = et0_q[ExW-1:14]; mul_b = et0_q[ExW-1:14]; end
      5'd17: begin mul_a = et1_q[ExW-1:14]; mul_b = et1_q[ExW-1:14]; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // product views for accumulation
  logic signed [ExW-1:0] prod_ex;
  logic signed [PW-1:0]  prod_p, ex2_p;
  assign prod_ex = prod_q[ExW-1:0];
  assign prod_p  = {{(PW-ProdW){prod_q[ProdW-1]}}, prod_q};
  assign ex2_p   = {{(PW-ExW){ex2_q[ExW-1]}}, ex2_q};

  // magnitude of the epipolar product
  logic [PW-1:0] p_abs;
  assign p_abs = p_q[PW-1] ? PW'(-p_q) : PW'(p_q);

  // square root and divide step
  logic [DW-1:0] sq_try;
  logic [SqW:0]  div_ext, div_s, div_diff;
  logic          div_ge;
  assign sq_try   = sq_res_q + sq_bit_q;
  assign div_ext  = {rem_q, num_q[NumW-1]};
  assign div_s    = {1'b0, sq_res_q[SqW-1:0]};
  assign div_ge   = (div_ext >= div_s);
  assign div_diff = div_ext - div_s;

  // sequencer
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    phase_d  = phase_q;
    iter_d   = iter_q;
    ex0_d    = ex0_q;
    ex1_d    = ex1_q;
    ex2_d    = ex2_q;
    et0_d    = et0_q;
    et1_d    = et1_q;
    p_d      = p_q;
    d_d      = d_q;
    sq_v_d   = sq_v_q;
    sq_res_d = sq_res_q;
    sq_bit_d = sq_bit_q;
    num_d    = num_q;
    rem_d    = rem_q;
    err_d    = err_q;
    inv_d    = inv_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          ex0_d   = sh14(e02[EntryW-1:0]);
          ex1_d   = sh14(e12[EntryW-1:0]);
          ex2_d   = sh14(e22[EntryW-1:0]);
          et0_d   = sh14(e20[EntryW-1:0]);
          et1_d   = sh14(e21[EntryW-1:0]);
          p_d     = '0;
          d_d     = '0;
          step_d  = '0;
          phase_d = 1'b0;
          state_d = F_MUL;
        end
      end
      F_MUL: begin
        phase_d = ~phase_q;
        if (phase_q) begin
          case (step_q)
            5'd0, 5'd1: ex0_d = ex0_q + prod_ex;
            5'd2, 5'd3: ex1_d = ex1_q + prod_ex;
            5'd4, 5'd5: ex2_d = ex2_q + prod_ex;
            5'd6, 5'd7: et0_d = et0_q + prod_ex;
            5'd8, 5'd9: et1_d = et1_q + prod_ex;
            5'd10: p_d = p_q + prod_p + (ex2_p <<< 14);
            5'd11, 5'd13: p_d = p_q + (prod_p <<< 21);
            5'd12: p_d = p_q + prod_p;
            default: d_d = d_q + {{(DW-ProdW){1'b0}}, prod_q};
          endcase
          step_d = step_q + StepW'(1);
          if (step_q == StepLast) begin
            state_d = F_PREP;
          end
        end
      end
      F_PREP: begin
        num_d    = {p_abs[PW-1:PW-MagW], 16'b0};
        sq_v_d   = d_q;
        sq_res_d = '0;
        sq_bit_d = DW'(1) << (DW - 2);
        iter_d   = '0;
        inv_d    = (d_q == '0);
        if (d_q == '0) begin
          err_d   = ErrMax;
          state_d = F_PUSH;
        end else begin
          state_d = F_SQRT;
        end
      end
      F_SQRT: begin
        if (sq_v_q >= sq_try) begin
          sq_v_d   = sq_v_q - sq_try;
          sq_res_d = (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_d = sq_res_q >> 1;
        end
        sq_bit_d = sq_bit_q >> 2;
        iter_d   = iter_q + IterW'(1);
        if (iter_q == SqrtLast) begin
          iter_d  = '0;
          rem_d   = '0;
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        rem_d  = div_ge ? div_diff[SqW-1:0] : div_ext[SqW-1:0];
        num_d  = {num_q[NumW-2:0], div_ge};
        iter_d = iter_q + IterW'(1);
        if (iter_q == DivLast) begin
          err_d   = (|num_d[NumW-1:ErrW]) ? ErrMax : num_d[ErrW-1:0];
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
      phase_q <= 1'b0;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      phase_q <= phase_d;
      iter_q  <= iter_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q     <= first_x_i;
      y_q     <= first_y_i;
      xp_q    <= second_x_i;
      yp_q    <= second_y_i;
      start_q <= run_start_i;
      last_q  <= model_last_i;
    end
    prod_q   <= prod_d;
    ex0_q    <= ex0_d;
    ex1_q    <= ex1_d;
    ex2_q    <= ex2_d;
    et0_q    <= et0_d;
    et1_q    <= et1_d;
    p_q      <= p_d;
    d_q      <= d_d;
    sq_v_q   <= sq_v_d;
    sq_res_q <= sq_res_d;
    sq_bit_q <= sq_bit_d;
    num_q    <= num_d;
    rem_q    <= rem_d;
    err_q    <= err_d;
    inv_q    <= inv_d;
  end

  assign push_o                 = (state_q == F_PUSH) && !full_i;
  assign push_item_o.err        = err_q;
  assign push_item_o.invalid    = inv_q;
  assign push_item_o.run_start  = start_q;
  assign push_item_o.model_last = last_q;

  // assertions
  a_push_invalid_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && push_item_o.invalid |-> push_item_o.err == ErrMax)
    else $error("invalid match pushed without saturated error");
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == F_MUL && step_q == '0)
    else $error("accepted match did not start the multiply sequence");
  a_div_after_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == F_DIV |-> sq_res_q[SqW-1:0] != '0)
    else $error("divide started with zero root");

endmodule
`default_nettype wire

// ----- hdl/sis_queue.sv -----
`default_nettype none
module sis_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sis_pkg::sis_item_t push_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output sis_pkg::sis_item_t pop_item_o
);
  import sis_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned FillW = $clog2(QueueDepth + 1);

  sis_item_t entries_q [QueueDepth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [FillW-1:0] fill_q;

  assign full_o     = (fill_q == FillW'(QueueDepth));
  assign empty_o    = (fill_q == '0);
  assign pop_item_o = entries_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wptr_q] <= push_item_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + FillW'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - FillW'(1);
      end
    end
  end

  // assertions
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue pop while empty");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(QueueDepth))
    else $error("queue fill level out of range");

endmodule
`default_nettype wire

// ----- hdl/sis_back.sv -----
`default_nettype none
module sis_back #(
  parameter int unsigned MAX_MATCHES = sis_pkg::MaxMatchesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [sis_pkg::ErrW-1:0]    threshold_i,
  input  logic                        empty_i,
  input  sis_pkg::sis_item_t          item_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sis_pkg::ErrW-1:0]    sampson_err_o,
  output logic                        is_inlier_o,
  output logic                        is_invalid_o,
  output logic [sis_pkg::CntW-1:0]    model_inliers_o,
  output logic [sis_pkg::SumW-1:0]    model_residual_o,
  output logic                        new_best_o,
  output logic                        model_done_o
);
  import sis_pkg::*;

  localparam logic [CntW-1:0] Cap =
    (MAX_MATCHES < ((1 << CntW) - 1)) ? CntW'(MAX_MATCHES) : '1;

  logic [CntW-1:0] model_count_q, best_count_q;
  logic [SumW-1:0] model_sum_q, best_sum_q;
  logic            out_valid_q;

  logic [CntW-1:0] cnt0, cnt1, bc0;
  logic [SumW-1:0] sum0, sum1, bs0;
  logic [SumW:0]   sum_ext;
  logic            inlier, better;

  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  // run start clears totals and best record before scoring
  assign cnt0 = item_i.run_start ? '0 : model_count_q;
  assign sum0 = item_i.run_start ? '0 : model_sum_q;
  assign bc0  = item_i.run_start ? '0 : best_count_q;
  assign bs0  = item_i.run_start ? SumMax : best_sum_q;

  // inlier test and saturating totals
  assign inlier  = !item_i.invalid && (item_i.err < threshold_i);
  assign sum_ext = {1'b0, sum0} + {{(SumW + 1 - ErrW){1'b0}}, item_i.err};
  assign cnt1    = (inlier && cnt0 < Cap) ? cnt0 + CntW'(1) : cnt0;
  assign sum1    = inlier ? (sum_ext[SumW] ? SumMax : sum_ext[SumW-1:0]) : sum0;

  // best record compare on model close
  assign better = item_i.model_last &&
                  ((cnt1 > bc0) || ((cnt1 == bc0) && (sum1 < bs0)));

  // totals and best record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_count_q <= '0;
      model_sum_q   <= '0;
      best_count_q  <= '0;
      best_sum_q    <= SumMax;
      out_valid_q   <= 1'b0;
    end else begin
      if (pop_o) begin
        model_count_q <= item_i.model_last ? '0 : cnt1;
        model_sum_q   <= item_i.model_last ? '0 : sum1;
        best_count_q  <= better ? cnt1 : bc0;
        best_sum_q    <= better ? sum1 : bs0;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sampson_err_o    <= item_i.err;
      is_inlier_o      <= inlier;
      is_invalid_o     <= item_i.invalid;
      model_inliers_o  <= cnt1;
      model_residual_o <= sum1;
      new_best_o       <= better;
      model_done_o     <= item_i.model_last;
    end
  end

  assign out_valid_o = out_valid_q;

  // assertions
  a_inlier_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && is_inlier_o |-> !is_invalid_o)
    else $error("invalid match reported as inlier");
  a_best_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && new_best_o |-> model_done_o)
    else $error("new best outside model close");
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    model_count_q <= Cap)
    else $error("inlier count above cap");
  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && item_i.model_last |=> model_count_q == '0 && model_sum_q == '0)
    else $error("model totals not cleared on close");

endmodule
`default_nettype wire
